>>> rtl/stl_pkg.sv
// Shared types, command codes and access-size decode for the segment translate unit.
package stl_pkg;

    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned SIZE_W  = 16;

    typedef enum logic [1:0] {
        CMD_TABLE_WRITE = 2'd0,
        CMD_XLATE_REG   = 2'd1,
        CMD_XLATE_BYTES = 2'd2,
        CMD_NONE        = 2'd3
    } cmd_t;

    localparam logic [SIZE_W-1:0] SIZE_WORD  = 16'd4;
    localparam logic [SIZE_W-1:0] SIZE_DWORD = 16'd8;
    localparam logic [SIZE_W-1:0] SIZE_QWORD = 16'd16;
    localparam logic [SIZE_W-1:0] SIZE_ZERO  = 16'd0;

    // Quotient and remainder handed from the divider to the top level.
    typedef struct packed {
        logic [ADDR_W-1:0] quotient;
        logic [ADDR_W-1:0] remainder;
    } div_result_t;

    function automatic logic [SIZE_W-1:0] access_size(
        input cmd_t              cmd,
        input logic [3:0]        reg_select,
        input logic [SIZE_W-1:0] byte_count
    );
        logic [SIZE_W-1:0] size;
        size = byte_count;
        if (cmd == CMD_XLATE_REG) begin
            case (reg_select) inside
                [4'd0:4'd3]:  size = SIZE_WORD;
                [4'd4:4'd7]:  size = SIZE_DWORD;
                [4'd8:4'd11]: size = SIZE_QWORD;
                default:      size = SIZE_ZERO;
            endcase
        end
        return size;
    endfunction

endpackage

>>> rtl/stl_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module stl_divider (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [stl_pkg::ADDR_W-1:0]        dividend,
    input  logic [stl_pkg::ADDR_W-1:0]        divisor,
    output logic                              done,
    output stl_pkg::div_result_t              result
);

    localparam int unsigned CNT_W = $clog2(stl_pkg::ADDR_W);

    logic                          busy_reg,  busy_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [stl_pkg::ADDR_W-1:0]    quo_reg,   quo_next;
    logic [stl_pkg::ADDR_W-1:0]    rem_reg,   rem_next;
    logic [stl_pkg::ADDR_W-1:0]    div_reg,   div_next;
    logic                          done_reg,  done_next;

    logic [stl_pkg::ADDR_W:0]      shifted;
    logic [stl_pkg::ADDR_W:0]      trial;
    logic                          fits;

    // Bring down the next dividend bit and try one subtract.
    assign shifted = {rem_reg, quo_reg[stl_pkg::ADDR_W-1]};
    assign trial   = shifted - {1'b0, div_reg};
    assign fits    = (shifted >= {1'b0, div_reg});

    always_comb
    begin
        busy_next  = busy_reg;
        count_next = count_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        done_next  = 1'b0;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            quo_next   = dividend;
            rem_next   = '0;
            div_next   = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[stl_pkg::ADDR_W-2:0], fits};
            rem_next = fits ? trial[stl_pkg::ADDR_W-1:0] : shifted[stl_pkg::ADDR_W-1:0];
            count_next = count_reg + 1'b1;
            if (count_reg == CNT_W'(stl_pkg::ADDR_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done             = done_reg;
    assign result.quotient  = quo_reg;
    assign result.remainder = rem_reg;

endmodule

>>> rtl/segment_translate_with_limit_check_unit.sv
// Top level of the segment translate unit: request intake, segment table, limit check, result.
//
// Requests enter on s_tvalid/s_tready/s_tdata with the command code in s_tuser;
// every request gives exactly one result on m_tvalid/m_tready/m_tdata with the
// fault flag in m_tuser. A table write loads base and limit of one entry and
// returns an all-zero result; command 3 returns an all-zero result and changes
// nothing. A translate splits the logical address by max_segment_size in a
// bit-serial divider, reads the table entry, checks offset plus access size
// against the limit and returns base plus offset or a fault.
// Steps: a table write or unused command goes from accept straight to output load;
// a translate runs 32 divider steps, one quotient bit each, then quotient capture,
// table read, limit check and output load. One request is in work at a time, so a
// new request is taken only once the last result is loaded into the output register.
// Reset: rst_n clears control, sets max_segment_size to 64 and marks every table
// entry empty, which reads as base 0, limit 0.
// Stall: the result sits in an output register and s_tready rises once it is
// loaded, so one more request is taken while the receiver stalls and waits in
// its last stage until the output register frees up.
// Write the configuration (cfg_wr_en/cfg_wr_data) only while no request is in work.
module segment_translate_with_limit_check_unit #(
    parameter int unsigned SEG_ENTRIES = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    // Configuration: max_segment_size
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data,
    // Request channel
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata from bit 0: logical_address[31:0], entry_index[3:0], entry_base[31:0],
    //                     entry_limit[31:0], reg_select[3:0], byte_count[15:0]
    input  logic [119:0] s_tdata,
    // s_tuser from bit 0: cmd[1:0]
    input  logic [1:0]   s_tuser,
    // Result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata from bit 0: physical_address[31:0], segment_number[31:0],
    //                     segment_offset[31:0]
    output logic [95:0]  m_tdata,
    // m_tuser from bit 0: fault
    output logic         m_tuser
);

    localparam int unsigned IDX_W = (SEG_ENTRIES > 1) ? $clog2(SEG_ENTRIES) : 1;
    localparam int unsigned AW    = stl_pkg::ADDR_W;
    localparam int unsigned SW    = stl_pkg::SIZE_W;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DIVIDE = 5'b00010,
        ST_LOOKUP = 5'b00100,
        ST_CHECK  = 5'b01000,
        ST_SEND   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Unpack the request.
    stl_pkg::cmd_t    in_cmd;
    logic [AW-1:0]    in_laddr;
    logic [3:0]       in_index;
    logic [AW-1:0]    in_base;
    logic [AW-1:0]    in_limit;
    logic [3:0]       in_rsel;
    logic [SW-1:0]    in_bcount;

    assign in_cmd    = stl_pkg::cmd_t'(s_tuser);
    assign in_laddr  = s_tdata[31:0];
    assign in_index  = s_tdata[35:32];
    assign in_base   = s_tdata[67:36];
    assign in_limit  = s_tdata[99:68];
    assign in_rsel   = s_tdata[103:100];
    assign in_bcount = s_tdata[119:104];

    logic accept;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Configuration register.
    logic [AW-1:0] seg_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seg_size_reg <= 32'd64;
        else if (cfg_wr_en)
            seg_size_reg <= cfg_wr_data;
    end

    // Segment table: base and limit memories, per-entry valid bits.
    logic [AW-1:0]          base_mem  [SEG_ENTRIES];
    logic [AW-1:0]          limit_mem [SEG_ENTRIES];
    logic [SEG_ENTRIES-1:0] valid_reg;
    logic                   tbl_wr;
    logic [IDX_W-1:0]       tbl_wr_idx;

    assign tbl_wr     = accept && (in_cmd == stl_pkg::CMD_TABLE_WRITE)
                        && (32'(in_index) < 32'(SEG_ENTRIES));
    assign tbl_wr_idx = IDX_W'(in_index);

    always_ff @(posedge clk)
    begin
        if (tbl_wr)
        begin
            base_mem[tbl_wr_idx]  <= in_base;
            limit_mem[tbl_wr_idx] <= in_limit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (tbl_wr)
            valid_reg[tbl_wr_idx] <= 1'b1;
    end

    // Divider.
    logic                 div_start;
    logic                 div_done;
    stl_pkg::div_result_t div_result;

    stl_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (in_laddr),
        .divisor  (seg_size_reg),
        .done     (div_done),
        .result   (div_result)
    );

    // Per-request working registers.
    logic [SW-1:0]  size_reg;
    logic [AW-1:0]  seg_reg;
    logic [AW-1:0]  off_reg;
    logic           in_range;
    logic [IDX_W-1:0] rd_idx;
    logic [AW-1:0]  rd_base_reg;
    logic [AW-1:0]  rd_limit_reg;
    logic           rd_valid_reg;

    // Result waiting for the output register.
    logic [AW-1:0]  res_phys_reg;
    logic           res_fault_reg;
    logic [AW-1:0]  res_seg_reg;
    logic [AW-1:0]  res_off_reg;

    // Output register.
    logic           m_valid_reg;
    logic [AW-1:0]  m_phys_reg;
    logic           m_fault_reg;
    logic [AW-1:0]  m_seg_reg;
    logic [AW-1:0]  m_off_reg;
    logic           out_free;

    assign out_free  = !m_valid_reg || m_tready;
    assign div_start = accept && ((in_cmd == stl_pkg::CMD_XLATE_REG)
                                  || (in_cmd == stl_pkg::CMD_XLATE_BYTES));
    assign in_range  = (seg_reg < 32'(SEG_ENTRIES));
    assign rd_idx    = seg_reg[IDX_W-1:0];

    // Limit check: offset plus size without wrap-around, against the limit.
    logic [AW-1:0] eff_base;
    logic [AW-1:0] eff_limit;
    logic [AW:0]   reach;
    logic          chk_fault;

    assign eff_base  = rd_valid_reg ? rd_base_reg  : '0;
    assign eff_limit = rd_valid_reg ? rd_limit_reg : '0;
    assign reach     = {1'b0, off_reg} + {{(AW+1-SW){1'b0}}, size_reg};
    assign chk_fault = !in_range || (reach > {1'b0, eff_limit});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = div_start ? ST_DIVIDE : ST_SEND;
            end
            ST_DIVIDE:
            begin
                if (div_done)
                    state_next = ST_LOOKUP;
            end
            ST_LOOKUP: state_next = ST_CHECK;
            ST_CHECK:  state_next = ST_SEND;
            ST_SEND:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_SEND) && out_free)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // Payload: no reset needed.
    always_ff @(posedge clk)
    begin
        if (accept)
            size_reg <= stl_pkg::access_size(in_cmd, in_rsel, in_bcount);

        // Hold the quotient and remainder once the last step lands.
        if ((state_reg == ST_DIVIDE) && div_done)
        begin
            seg_reg <= div_result.quotient;
            off_reg <= div_result.remainder;
        end

        // Registered table read at the segment number.
        rd_base_reg  <= base_mem[rd_idx];
        rd_limit_reg <= limit_mem[rd_idx];
        rd_valid_reg <= valid_reg[rd_idx];

        // Table writes and the unused command return zeros.
        if (accept && !div_start)
        begin
            res_phys_reg  <= '0;
            res_fault_reg <= 1'b0;
            res_seg_reg   <= '0;
            res_off_reg   <= '0;
        end
        else if (state_reg == ST_CHECK)
        begin
            res_phys_reg  <= chk_fault ? '0 : (eff_base + off_reg);
            res_fault_reg <= chk_fault;
            res_seg_reg   <= seg_reg;
            res_off_reg   <= off_reg;
        end

        if ((state_reg == ST_SEND) && out_free)
        begin
            m_phys_reg  <= res_phys_reg;
            m_fault_reg <= res_fault_reg;
            m_seg_reg   <= res_seg_reg;
            m_off_reg   <= res_off_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_off_reg, m_seg_reg, m_phys_reg};
    assign m_tuser  = m_fault_reg;

endmodule
